[hdl/stxr_pkg.sv]
// Shared types and constants of the STX/ETX tag frame receiver.
`default_nettype none

package stxr_pkg;

    // Frame store depth default; byte_index is 6 bits, so at most 64
    localparam int MAX_FRAME_BYTES_DEF = 12;

    // Command queue between front end and back end
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tag_byte;
        logic [5:0] byte_index;
        logic       last;
        logic       frame_empty;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_RELEASE = 2'd0,
        OP_STX     = 2'd1,
        OP_ETX     = 2'd2,
        OP_DATA    = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RECV = 2'd1,
        MODE_HELD = 2'd2
    } t_mode;

    typedef enum logic {
        EX_CMD  = 1'b0,
        EX_EMIT = 1'b1
    } t_exec_state;

endpackage

`default_nettype wire

[hdl/stxr_front.sv]
// Front end: takes input words, decodes them into commands, drops fill bytes.
`default_nettype none

module stxr_front
    import stxr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept;
    logic keep;
    t_cmd dec_cmd;

    // decode
    always_comb begin
        keep         = 1'b1;
        dec_cmd.data = i_in_word.rx_byte;
        dec_cmd.op   = OP_DATA;
        if (i_in_word.kind) begin
            dec_cmd.op = OP_RELEASE;
        end else if (i_in_word.rx_byte == BYTE_STX) begin
            dec_cmd.op = OP_STX;
        end else if (i_in_word.rx_byte == BYTE_ETX) begin
            dec_cmd.op = OP_ETX;
        end else if (i_in_word.rx_byte == BYTE_NUL || i_in_word.rx_byte == BYTE_CR ||
                     i_in_word.rx_byte == BYTE_LF) begin
            keep = 1'b0;
        end
    end

    assign o_in_ready = !r_valid || i_cmd_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid = keep;
            n_cmd   = dec_cmd;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

[hdl/stxr_cmd_fifo.sv]
// Short command queue between front end and back end.
`default_nettype none

module stxr_cmd_fifo
    import stxr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_cmd,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_cmd      o_pop_cmd
);

    localparam int PW = $clog2(CMD_FIFO_DEPTH);
    localparam logic [PW:0] FULL_CNT = (PW + 1)'(CMD_FIFO_DEPTH);

    t_cmd           r_mem [CMD_FIFO_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PW:0]    r_cnt, n_cnt;
    logic           push, pop;

    assign o_push_ready = r_cnt != FULL_CNT;
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/stxr_back.sv]
// Back end: frame mode, fill count, frame store and result emission.
`default_nettype none

module stxr_back
    import stxr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    input  wire t_cmd  i_cmd,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_word  o_out_word
);

    localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

    logic [7:0]    r_store [MAX_FRAME_BYTES];
    t_exec_state   r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;
    t_out_word     emit_word;
    logic          store_we;
    logic          is_empty;

    // result for the current emit position
    always_comb begin
        is_empty              = r_count == '0;
        emit_word.frame_empty = is_empty;
        emit_word.tag_byte    = is_empty ? 8'h00 : r_store[r_idx];
        emit_word.byte_index  = 6'(r_idx);
        emit_word.last        = is_empty || (CW'(r_idx) + 1'b1 == r_count);
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        store_we    = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            EX_CMD: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_RELEASE: begin
                            if (r_mode == MODE_HELD) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                        OP_STX: begin
                            if (r_mode != MODE_HELD) begin
                                n_count = '0;
                                n_mode  = MODE_RECV;
                            end
                        end
                        OP_ETX: begin
                            if (r_mode == MODE_RECV) begin
                                n_mode  = MODE_HELD;
                                n_idx   = '0;
                                n_state = EX_EMIT;
                            end
                        end
                        OP_DATA: begin
                            if (r_mode == MODE_RECV) begin
                                if (r_count < MAX_CNT) begin
                                    store_we = 1'b1;
                                    n_count  = r_count + 1'b1;
                                end else begin
                                    // overlong frame is dropped
                                    n_count = '0;
                                    n_mode  = MODE_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            EX_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = emit_word;
                    if (emit_word.last) begin
                        n_state = EX_CMD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = EX_CMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EX_CMD;
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[AW-1:0]] <= i_cmd.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("fill count beyond store depth");

    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == EX_EMIT |-> r_mode == MODE_HELD)
        else $error("emitting outside held mode");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_empty |-> r_out.last && r_out.tag_byte == 8'h00)
        else $error("empty frame result not last or tag not zero");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == EX_EMIT && n_out_valid && !r_out_valid && emit_word.last
        |=> r_state == EX_CMD)
        else $error("emission did not end after last result");
`endif

endmodule

`default_nettype wire

[hdl/stx_etx_tag_frame_receiver_unit.sv]
// Top level of the STX/ETX tag frame receiver.
//
//  channel   direction  handshake                     word
//  ------    ---------  ----------------------------  -----------------------------
//  in        sink       i_in_valid / o_in_ready        i_in_word  (kind, rx_byte)
//  out       source     o_out_valid / i_out_ready      o_out_word (tag_byte,
//                                                       byte_index, last, frame_empty)
//
// Flow: a byte or release word is decoded into a registered command, queued,
// and executed by the back end. An ETX then walks the frame store, one result
// per cycle while the output is not stalled; a frame of N bytes gives N
// results, an empty frame one; the back end takes no command until the walk is done.
// Reset: i_rst_n synchronous, active low; mode idle, count zero, queue empty.
// Stalls: the four-entry command queue lets input words keep arriving while
// results are stalled; the output register decouples the result side.
`default_nettype none

module stx_etx_tag_frame_receiver_unit
    import stxr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    // front end -> queue
    logic f_cmd_valid;
    logic f_cmd_ready;
    t_cmd f_cmd;

    // queue -> back end
    logic q_cmd_valid;
    logic q_cmd_ready;
    t_cmd q_cmd;

    // decode and drop of NUL, CR and LF bytes
    stxr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_ready (f_cmd_ready),
        .o_cmd       (f_cmd)
    );

    // command queue
    stxr_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_cmd_valid),
        .o_push_ready (f_cmd_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_cmd_valid),
        .i_pop_ready  (q_cmd_ready),
        .o_pop_cmd    (q_cmd)
    );

    // frame state, store and result walk
    stxr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_cmd_valid),
        .o_cmd_ready (q_cmd_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[tb/stxr_frame_checker.sv]
// Frame receiver checker: predicts result words from accepted input words and compares them.
module stxr_frame_checker
    import stxr_pkg::*;
#(
    parameter int MAX_BYTES = MAX_FRAME_BYTES_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_mode      rx_mode;
    int         fill_level;
    logic [7:0] tag_store [MAX_BYTES];
    t_out_word  pending_tags [$];

    // Advance the frame state by one input word and queue any result words.
    function automatic void apply_rx_word(input t_in_word w);
        int n;
        if (w.kind) begin
            if (rx_mode == MODE_HELD)
                rx_mode = MODE_IDLE;
            return;
        end
        if (rx_mode == MODE_HELD)
            return;
        if (w.rx_byte == BYTE_STX) begin
            fill_level = 0;
            rx_mode    = MODE_RECV;
        end else if (w.rx_byte == BYTE_ETX) begin
            if (rx_mode != MODE_RECV)
                return;
            rx_mode = MODE_HELD;
            if (fill_level == 0)
                pending_tags.push_back(t_out_word'{8'h00, 6'd0, 1'b1, 1'b1});
            else
                for (n = 0; n < fill_level; n++)
                    pending_tags.push_back(t_out_word'{tag_store[n], 6'(n),
                                                       1'(n == fill_level - 1), 1'b0});
        end else if (w.rx_byte == BYTE_NUL || w.rx_byte == BYTE_CR
                     || w.rx_byte == BYTE_LF) begin
            return;
        end else if (rx_mode == MODE_RECV) begin
            if (fill_level < MAX_BYTES) begin
                tag_store[fill_level] = w.rx_byte;
                fill_level++;
            end else begin
                // overlong frame is dropped
                fill_level = 0;
                rx_mode    = MODE_IDLE;
            end
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            rx_mode      = MODE_IDLE;
            fill_level   = 0;
            pending_tags.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                apply_rx_word(i_in_word);
            if (i_out_valid && i_out_ready) begin
                if (pending_tags.size() == 0) begin
                    $error("unexpected result word: tag_byte 0x%0h byte_index %0d",
                           i_out_word.tag_byte, i_out_word.byte_index);
                    o_fail_count++;
                end else begin
                    want = pending_tags.pop_front();
                    check_field("tag_byte", want.tag_byte, i_out_word.tag_byte);
                    check_field("byte_index", 8'(want.byte_index), 8'(i_out_word.byte_index));
                    check_field("last", 8'(want.last), 8'(i_out_word.last));
                    check_field("frame_empty", 8'(want.frame_empty),
                                8'(i_out_word.frame_empty));
                    o_checked++;
                end
            end
        end
        o_pending = pending_tags.size();
    end

endmodule

[tb/tb_stx_etx_tag_frame_receiver_unit.sv]
// Testbench top for the STX/ETX tag frame receiver: stimulus, result sink and verdict.
module tb_stx_etx_tag_frame_receiver_unit;
    import stxr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES    = MAX_FRAME_BYTES_DEF;
    localparam int HOLD_CYCLES  = 300;   // long result-side hold-off, fills the command queue
    localparam int STUCK_LIMIT  = 3000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES = 40;    // tail after the last expected word
    localparam int RANDOM_WORDS = 40;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    int fail_count;
    int pending;
    int checked;

    // shared between the stimulus and the result sink
    logic no_gaps;        // both sides run without idle cycles
    logic stall_request;  // asks the sink for one long hold-off

    int words_sent;
    int frame_words;      // words that move the frame state, noise excluded
    int frames_sent;
    int frames_dropped;
    int stuck_cycles;

    stx_etx_tag_frame_receiver_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    stxr_frame_checker #(.MAX_BYTES(MAX_BYTES)) u_frame_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A data byte that the block will store: anything but the framing and
    // filler codes.
    function automatic logic [7:0] pick_tag_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_STX || b == BYTE_ETX || b == BYTE_NUL
               || b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    // Offer one input word after a random gap and hold it until accepted.
    // Valid is only dropped when a gap is drawn, so back-to-back words never
    // see a low/high pair of assignments in the same step.
    task automatic push_word(input logic word_kind, input logic [7:0] word_byte);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= t_in_word'{word_kind, word_byte};
        do @(posedge clk); while (!(in_valid && in_ready));
        words_sent++;
    endtask

    // One frame: STX, len data bytes with the odd filler or stray release
    // mixed in, then ETX. Frames that fit are followed by a little junk while
    // held and then the release; overlong ones are dropped by the block, so
    // their trailing ETX lands in idle and is ignored.
    task automatic send_frame(input int len);
        int n;
        int sel;
        push_word(1'b0, BYTE_STX);
        frame_words++;
        for (n = 0; n < len; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                sel = $urandom_range(0, 3);
                case (sel)
                    0: push_word(1'b0, BYTE_NUL);
                    1: push_word(1'b0, BYTE_CR);
                    2: push_word(1'b0, BYTE_LF);
                    default: push_word(1'b1, 8'($urandom_range(0, 255)));
                endcase
            end
            push_word(1'b0, pick_tag_byte());
            frame_words++;
        end
        push_word(1'b0, BYTE_ETX);
        if (len > MAX_BYTES) begin
            frames_dropped++;
        end else begin
            frame_words++;
            frames_sent++;
            repeat ($urandom_range(0, 2)) push_word(1'b0, 8'($urandom_range(0, 255)));
            push_word(1'b1, 8'($urandom_range(0, 255)));
            frame_words++;
        end
    endtask

    // Result sink: per word a random stall, none in no-gap stretches, and one
    // long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int hold;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (stall_request) begin
                hold          = HOLD_CYCLES;
                stall_request = 1'b0;
            end else if (no_gaps) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 3);
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Watchdog: any accepted word on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d result words outstanding",
                     STUCK_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        int len;
        int r;
        int n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_word        = '0;
        no_gaps        = 1'b0;
        stall_request  = 1'b0;
        words_sent     = 0;
        frame_words    = 0;
        frames_sent    = 0;
        frames_dropped = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: ignored words in idle, empty frame, junk while held
        // (STX too), filler codes while receiving, stray release mid-frame,
        // restart by STX, and data bytes at both ends of the range.
        push_word(1'b0, 8'h41);       // data while idle
        push_word(1'b0, BYTE_ETX);    // ETX while idle
        push_word(1'b1, 8'hFF);       // release while idle
        push_word(1'b0, BYTE_STX);
        push_word(1'b0, BYTE_ETX);    // empty frame
        push_word(1'b0, BYTE_STX);    // held: ignored
        push_word(1'b0, 8'h55);       // held: ignored
        push_word(1'b1, 8'h00);       // release
        push_word(1'b0, BYTE_STX);
        push_word(1'b0, BYTE_NUL);
        push_word(1'b0, BYTE_CR);
        push_word(1'b0, BYTE_LF);
        push_word(1'b0, 8'hFF);
        push_word(1'b1, 8'hAA);       // release while receiving: ignored
        push_word(1'b0, BYTE_STX);    // restart, drops the 0xFF
        push_word(1'b0, 8'h01);
        push_word(1'b0, 8'h80);
        push_word(1'b0, 8'h7F);
        push_word(1'b0, BYTE_ETX);
        push_word(1'b1, 8'h00);

        // Back pressure: the sink holds off while full-size frames stream in
        // with no gaps, so the command queue fills and the input stalls.
        no_gaps       = 1'b1;
        stall_request = 1'b1;
        send_frame(MAX_BYTES);
        send_frame(MAX_BYTES);
        send_frame(MAX_BYTES + 1);
        no_gaps = 1'b0;

        frame_words = 0;
        while (frame_words < RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // plain noise, any kind and any byte
                repeat ($urandom_range(1, 4))
                    push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
                if (r == 1) begin
                    // broken start: partial frame cut short by a fresh STX
                    push_word(1'b0, BYTE_STX);
                    frame_words++;
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        push_word(1'b0, pick_tag_byte());
                        frame_words++;
                    end
                end
                r = $urandom_range(0, 15);
                if (r == 15)
                    len = MAX_BYTES + 1;
                else if (r == 14)
                    len = MAX_BYTES;
                else
                    len = $urandom_range(0, MAX_BYTES);
                send_frame(len);
            end
        end
        no_gaps = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input words: %0d frames emitted, %0d dropped as overlong,",
                 words_sent, frames_sent, frames_dropped);
        $display("plus idle and held junk and one long result stall; %0d result words checked",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
hdl/stxr_pkg.sv
hdl/stxr_front.sv
hdl/stxr_cmd_fifo.sv
hdl/stxr_back.sv
hdl/stx_etx_tag_frame_receiver_unit.sv
tb/stxr_frame_checker.sv
tb/tb_stx_etx_tag_frame_receiver_unit.sv
